/* src/olad_pkg.sv */
package olad_pkg;

    localparam int unsigned DEFAULT_CAPACITY = 16;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned COUNT_W  = 5;

    localparam logic [STATUS_W-1:0] ST_APPENDED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } state_t;

endpackage

/* src/ordered_list_append_delete_by_value_core.sv */
// Fixed-capacity ordered list of signed 32-bit values held in a single-port-write,
// registered-read memory with the head at entry 0. Append writes the tail entry,
// or reports full when the list is at capacity. Delete scans from the head with one
// shared 32-bit comparator, one entry at a time (memory read, then compare), and
// on a hit moves each later entry up one place (read, then write); a delete on an
// empty list reports empty without a scan. One item is worked at a time; the
// result register lets the next item transfer while a result is still stalled.
module ordered_list_append_delete_by_value_core
    import olad_pkg::*;
#(
    parameter int unsigned CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic                       action,
    input  logic signed [VALUE_W-1:0]  value,

    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [STATUS_W-1:0]        status,
    output logic [COUNT_W-1:0]         entry_count
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    logic [VALUE_W-1:0] mem [CAPACITY];

    state_t             state_reg, state_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VALUE_W-1:0] rd_data_reg;

    logic               result_valid_reg, result_valid_next;
    logic [STATUS_W-1:0] result_status_reg;
    logic [COUNT_W-1:0] result_count_reg;
    logic               load_result;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [AW-1:0]      rd_addr;

    logic [CW:0]        idx_plus1;
    logic [CW:0]        idx_plus2;
    logic [CW+COUNT_W-1:0] count_ext;

    assign idx_plus1 = (CW+1)'(idx_reg) + (CW+1)'(1);
    assign idx_plus2 = (CW+1)'(idx_reg) + (CW+1)'(2);
    assign count_ext = {{COUNT_W{1'b0}}, count_reg};

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        value_next  = value_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = value;
        rd_addr     = idx_reg;
        load_result = 1'b0;
        item_stall  = (state_reg != S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    value_next = value;
                    if (action == ACT_APPEND)
                    begin
                        if (count_reg >= CAP_COUNT)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = count_reg[AW-1:0];
                            count_next  = count_reg + CW'(1);
                            status_next = ST_APPENDED;
                        end
                        state_next = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_SRCH_RD;
                    end
                end
            end

            S_SRCH_RD:
            begin
                rd_addr    = idx_reg;
                state_next = S_SRCH_CMP;
            end

            S_SRCH_CMP:
            begin
                if (rd_data_reg == value_reg)
                begin
                    if (idx_plus1 < (CW+1)'(count_reg))
                    begin
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        // hit on the tail entry: nothing to move
                        count_next  = count_reg - CW'(1);
                        status_next = ST_DELETED;
                        state_next  = S_DONE;
                    end
                end
                else if (idx_plus1 < (CW+1)'(count_reg))
                begin
                    idx_next   = idx_plus1[AW-1:0];
                    state_next = S_SRCH_RD;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
            end

            S_SHIFT_RD:
            begin
                rd_addr    = idx_plus1[AW-1:0];
                state_next = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                // move the later entry up one place
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data_reg;
                if (idx_plus2 < (CW+1)'(count_reg))
                begin
                    idx_next   = idx_plus1[AW-1:0];
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    count_next  = count_reg - CW'(1);
                    status_next = ST_DELETED;
                    state_next  = S_DONE;
                end
            end

            S_DONE:
            begin
                // hold until the result register is free
                if (!result_valid_reg || !result_stall)
                begin
                    load_result = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        if (load_result)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        if (load_result)
        begin
            result_status_reg <= status_reg;
            result_count_reg  <= count_ext[COUNT_W-1:0];
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = result_status_reg;
    assign entry_count  = result_count_reg;

endmodule
